// ===== sv/color_palette_indexer_macros.svh =====
// Assertion macros for the color palette indexer checker.
// Expects signals named clock and reset in the scope of each use.
`ifndef COLOR_PALETTE_INDEXER_MACROS_SVH
`define COLOR_PALETTE_INDEXER_MACROS_SVH

// same-cycle implication
`define CPI_CHECK(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CPI_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/cpi_pkg.sv =====
// Shared constants and the beat record that travels down the palette cell chain.
// No dependencies.
package cpi_pkg;

   localparam int PALETTE_DEPTH = 256;   // 2 .. 256
   localparam int COLOR_W       = 32;
   localparam int IDX_W         = 8;
   localparam int COUNT_W       = 9;

   typedef struct packed {
      logic               new_image;
      logic [COLOR_W-1:0] color;      // {red, green, blue, alpha}
      logic               found;      // matched or appended somewhere upstream
      logic               added;
      logic [IDX_W-1:0]   index;
      logic [COUNT_W-1:0] count;      // occupied entries seen so far
   } beat_type;

endpackage

// ===== sv/color_palette_indexer.sv =====
// First-seen color palette builder: a chain of PALETTE_DEPTH cells, one entry each.
// An accepted pixel passes through the register of every cell, then the cpi_out result register.
// Throughput: one pixel per clock; pixels follow each other down the cell chain.
// The whole chain advances together and halts while a result beat is stalled.
// Reset (synchronous) empties every cell and clears the sticky overflow flag.
// Uses cpi_pkg, cpi_cell and cpi_out.
module color_palette_indexer
   import cpi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_new_image,
   input  logic [7:0]         req_red,
   input  logic [7:0]         req_green,
   input  logic [7:0]         req_blue,
   input  logic [7:0]         req_alpha,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [IDX_W-1:0]   rsp_color_index,
   output logic               rsp_added,
   output logic               rsp_overflow,
   output logic [COUNT_W-1:0] rsp_colors_used
);

   logic     advance;
   logic     chain_valid [PALETTE_DEPTH+1];
   beat_type chain_beat  [PALETTE_DEPTH+1];

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   always_comb begin
      chain_valid[0]          = req_valid;
      chain_beat[0].new_image = req_new_image;
      chain_beat[0].color     = {req_red, req_green, req_blue, req_alpha};
      chain_beat[0].found     = 1'b0;
      chain_beat[0].added     = 1'b0;
      chain_beat[0].index     = '0;
      chain_beat[0].count     = '0;
   end

   for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
      cpi_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .cell_index (IDX_W'(i)),
         .in_valid   (chain_valid[i]),
         .in_beat    (chain_beat[i]),
         .out_valid  (chain_valid[i+1]),
         .out_beat   (chain_beat[i+1])
      );
   end

   cpi_out u_out (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .tail_valid      (chain_valid[PALETTE_DEPTH]),
      .tail_beat       (chain_beat[PALETTE_DEPTH]),
      .rsp_valid       (rsp_valid),
      .rsp_color_index (rsp_color_index),
      .rsp_added       (rsp_added),
      .rsp_overflow    (rsp_overflow),
      .rsp_colors_used (rsp_colors_used)
   );

endmodule

// ===== sv/cpi_cell.sv =====
// One palette cell: holds a single entry, compares the passing beat against it,
// claims the entry on first miss, and forwards the beat. Uses cpi_pkg.
module cpi_cell
   import cpi_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic [IDX_W-1:0] cell_index,
   input  logic             in_valid,
   input  beat_type         in_beat,
   output logic             out_valid,
   output beat_type         out_beat
);

   logic [COLOR_W-1:0] entry_ff;
   logic [COLOR_W-1:0] entry_in;
   logic               used_ff;
   logic               used_in;
   logic               valid_ff;
   beat_type           beat_ff;
   beat_type           beat_in;
   logic               occupied;
   logic               hit;
   logic               claim;

   always_comb begin
      // a start-of-image beat wipes each cell as it goes by
      occupied = used_ff & ~in_beat.new_image;
      hit      = occupied && (entry_ff == in_beat.color) && !in_beat.found;
      claim    = !occupied && !in_beat.found;

      beat_in  = in_beat;
      entry_in = entry_ff;
      used_in  = used_ff;
      if (in_valid) begin
         used_in = occupied | claim;
         if (claim) begin
            entry_in = in_beat.color;
         end
         if (hit || claim) begin
            beat_in.found = 1'b1;
            beat_in.index = cell_index;
         end
         beat_in.added = in_beat.added | claim;
         beat_in.count = in_beat.count + COUNT_W'(occupied | claim);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else if (advance) begin
         used_ff  <= used_in;
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_ff <= entry_in;
         beat_ff  <= beat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

// ===== sv/cpi_out.sv =====
// Output stage: sticky overflow tracking and the result register.
// Uses cpi_pkg.
module cpi_out
   import cpi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               tail_valid,
   input  beat_type           tail_beat,
   output logic               rsp_valid,
   output logic [IDX_W-1:0]   rsp_color_index,
   output logic               rsp_added,
   output logic               rsp_overflow,
   output logic [COUNT_W-1:0] rsp_colors_used
);

   logic               sticky_ff;
   logic               sticky_in;
   logic               valid_ff;
   logic [IDX_W-1:0]   index_ff;
   logic [IDX_W-1:0]   index_in;
   logic               added_ff;
   logic               overflow_ff;
   logic [COUNT_W-1:0] used_ff;

   always_comb begin
      // no match and no free cell means the palette was full
      sticky_in = (sticky_ff & ~tail_beat.new_image) | ~tail_beat.found;
      index_in  = tail_beat.found ? tail_beat.index : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sticky_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else if (advance) begin
         valid_ff <= tail_valid;
         if (tail_valid) begin
            sticky_ff <= sticky_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         index_ff    <= index_in;
         added_ff    <= tail_beat.added;
         overflow_ff <= sticky_in;
         used_ff     <= tail_beat.count;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_color_index = index_ff;
   assign rsp_added       = added_ff;
   assign rsp_overflow    = overflow_ff;
   assign rsp_colors_used = used_ff;

endmodule

// ===== sv/cpi_checker.sv =====
// Port-level checks for color_palette_indexer, bound to the top level.
// Uses cpi_pkg and color_palette_indexer_macros.svh.
`include "color_palette_indexer_macros.svh"

module cpi_checker
   import cpi_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [IDX_W-1:0]   rsp_color_index,
   input logic               rsp_added,
   input logic               rsp_overflow,
   input logic [COUNT_W-1:0] rsp_colors_used
);

   `CPI_CHECK_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_color_index) && $stable(rsp_colors_used),
      "stalled result beat changed")
   `CPI_CHECK(a_back_pressure, rsp_valid && rsp_stall, req_stall,
      "input taken while result is stalled")
   `CPI_CHECK(a_added_no_ovf, rsp_valid && rsp_added, !rsp_overflow,
      "append reported with overflow")
   `CPI_CHECK(a_added_count, rsp_valid && rsp_added,
      rsp_colors_used == ({1'b0, rsp_color_index} + COUNT_W'(1)),
      "appended index does not match count")
   `CPI_CHECK(a_count_range, rsp_valid,
      (rsp_colors_used != '0) && (rsp_colors_used <= COUNT_W'(PALETTE_DEPTH)),
      "colors_used out of range")

endmodule

bind color_palette_indexer cpi_checker u_cpi_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_color_index (rsp_color_index),
   .rsp_added       (rsp_added),
   .rsp_overflow    (rsp_overflow),
   .rsp_colors_used (rsp_colors_used)
);

// ===== test/tb.sv =====
// Self-checking testbench for color_palette_indexer: directed table, then random images.
// Needs cpi_pkg and the color_palette_indexer RTL; drives valid/stall on both channels.
module tb
   import cpi_pkg::*;
();

   localparam int RANDOM_ITEMS   = 1475;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PRINT_LIMIT    = 40;
   localparam int DIRECTED_ROWS  = 24;
   localparam int FILL_ROW       = 18;   // palette gets filled up before this row

   typedef struct packed {
      logic [IDX_W-1:0]   color_index;
      logic               added;
      logic               overflow;
      logic [COUNT_W-1:0] colors_used;
   } index_result_type;

   typedef struct packed {
      logic             new_image;
      logic [31:0]      color;
      logic             typed;
      index_result_type want;
   } directed_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_new_image = 1'b0;
   logic [7:0]         req_red = 8'h00;
   logic [7:0]         req_green = 8'h00;
   logic [7:0]         req_blue = 8'h00;
   logic [7:0]         req_alpha = 8'h00;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [IDX_W-1:0]   rsp_color_index;
   logic               rsp_added;
   logic               rsp_overflow;
   logic [COUNT_W-1:0] rsp_colors_used;

   color_palette_indexer uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_new_image   (req_new_image),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .req_alpha       (req_alpha),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_color_index (rsp_color_index),
      .rsp_added       (rsp_added),
      .rsp_overflow    (rsp_overflow),
      .rsp_colors_used (rsp_colors_used)
   );

   // predictor state
   logic [31:0]   palette_mem [PALETTE_DEPTH];
   int unsigned   palette_fill = 0;
   bit            overflow_flag = 1'b0;

   index_result_type expected_indices [$];
   index_result_type oldest_index;
   int               mismatch_count = 0;
   int               idle_cycles = 0;
   int               stall_left = 0;
   bit               sender_calm = 1'b0;

   directed_row_type directed_rows [DIRECTED_ROWS];
   logic [31:0]   color_pool [$];
   logic [31:0]   image_colors [$];
   logic [31:0]   pixel;
   logic          mark;
   bit            big_image;
   bit            first_image;
   int            random_sent;
   int            image_len;
   int            pool_size;
   int            row;
   int            k;
   int            p;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic index_result_type palette_predict(input logic new_image,
                                                        input logic [31:0] color);
      index_result_type res;
      bit               hit;
      int unsigned      slot;
      int               e;
      res  = '0;
      hit  = 1'b0;
      slot = 0;
      if (new_image) begin
         palette_fill  = 0;
         overflow_flag = 1'b0;
      end
      for (e = 0; e < PALETTE_DEPTH; e++) begin
         if (!hit && e < palette_fill && palette_mem[e] == color) begin
            hit  = 1'b1;
            slot = e;
         end
      end
      if (!hit) begin
         if (palette_fill < PALETTE_DEPTH) begin
            palette_mem[palette_fill] = color;
            slot = palette_fill;
            palette_fill++;
            res.added = 1'b1;
         end else begin
            overflow_flag = 1'b1;
            slot = 0;
         end
      end
      res.color_index = IDX_W'(slot);
      res.overflow    = overflow_flag;
      res.colors_used = COUNT_W'(palette_fill);
      return res;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < PRINT_LIMIT)
         $display("tb: mismatch %s: got %0d expected %0d", what, got, want);
      mismatch_count++;
   endtask

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_pixel(input logic new_image, input logic [31:0] color,
                             input logic typed, input index_result_type typed_result);
      int               gap;
      index_result_type predicted;
      gap = sender_calm ? 0 : idle_length();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_new_image = new_image;
      {req_red, req_green, req_blue, req_alpha} = color;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = palette_predict(new_image, color);
      expected_indices.push_back(typed ? typed_result : predicted);
      @(negedge clock);
   endtask

   // receiver back-pressure, with stretches of none at all
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
      end else if ($urandom_range(0, 99) < 8) begin
         rsp_stall  = 1'b0;
         stall_left = $urandom_range(20, 150);
      end else begin
         stall_left = idle_length();
         rsp_stall  = (stall_left != 0);
         if (stall_left > 0) stall_left--;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_indices.size() == 0) begin
            report_mismatch("result beat with nothing expected", rsp_color_index, 0);
         end else begin
            oldest_index = expected_indices.pop_front();
            if (rsp_color_index !== oldest_index.color_index)
               report_mismatch("color_index", rsp_color_index, oldest_index.color_index);
            if (rsp_added !== oldest_index.added)
               report_mismatch("added", rsp_added, oldest_index.added);
            if (rsp_overflow !== oldest_index.overflow)
               report_mismatch("overflow", rsp_overflow, oldest_index.overflow);
            if (rsp_colors_used !== oldest_index.colors_used)
               report_mismatch("colors_used", rsp_colors_used, oldest_index.colors_used);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   initial begin
      // new_image, color {r,g,b,a}, typed, {index, added, overflow, used}
      directed_rows = '{
         '{1'b0, 32'h00000000, 1'b1, '{8'd0, 1'b1, 1'b0, 9'd1}},    // first pixel after reset
         '{1'b0, 32'hFFFFFFFF, 1'b1, '{8'd1, 1'b1, 1'b0, 9'd2}},
         '{1'b0, 32'h00000000, 1'b1, '{8'd0, 1'b0, 1'b0, 9'd2}},
         '{1'b0, 32'h000000FF, 1'b1, '{8'd2, 1'b1, 1'b0, 9'd3}},    // alpha alone
         '{1'b0, 32'h0000FF00, 1'b1, '{8'd3, 1'b1, 1'b0, 9'd4}},
         '{1'b0, 32'h00FF0000, 1'b1, '{8'd4, 1'b1, 1'b0, 9'd5}},
         '{1'b0, 32'hFF000000, 1'b1, '{8'd5, 1'b1, 1'b0, 9'd6}},
         '{1'b0, 32'hFFFFFF00, 1'b1, '{8'd6, 1'b1, 1'b0, 9'd7}},    // white but alpha 0
         '{1'b0, 32'hFFFFFFFF, 1'b1, '{8'd1, 1'b0, 1'b0, 9'd7}},
         '{1'b1, 32'hFFFFFFFF, 1'b1, '{8'd0, 1'b1, 1'b0, 9'd1}},    // start marker clears
         '{1'b0, 32'h00000000, 1'b1, '{8'd1, 1'b1, 1'b0, 9'd2}},
         '{1'b1, 32'h00000000, 1'b1, '{8'd0, 1'b1, 1'b0, 9'd1}},
         '{1'b1, 32'h00000000, 1'b1, '{8'd0, 1'b1, 1'b0, 9'd1}},    // back-to-back markers
         '{1'b0, 32'h01020304, 1'b0, '0},
         '{1'b0, 32'h80402010, 1'b0, '0},
         '{1'b0, 32'h7F7F7F7F, 1'b0, '0},
         '{1'b0, 32'h01020304, 1'b0, '0},
         '{1'b0, 32'h00000000, 1'b0, '0},
         '{1'b0, 32'h12345678, 1'b1, '{8'd0, 1'b0, 1'b1, 9'd256}},  // full, new color
         '{1'b0, 32'h01020304, 1'b1, '{8'd1, 1'b0, 1'b1, 9'd256}},  // known color after overflow
         '{1'b0, 32'hDEADBEEF, 1'b0, '0},
         '{1'b1, 32'h12345678, 1'b1, '{8'd0, 1'b1, 1'b0, 9'd1}},    // marker clears overflow
         '{1'b0, 32'h12345678, 1'b1, '{8'd0, 1'b0, 1'b0, 9'd1}},
         '{1'b0, 32'hFFFFFFFF, 1'b0, '0}
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (row = 0; row < DIRECTED_ROWS; row++) begin
         if (row == FILL_ROW) begin
            k = 0;
            while (palette_fill < PALETTE_DEPTH) begin
               send_pixel(1'b0, 32'hC33C0000 + k, 1'b0, '0);
               k++;
            end
         end
         send_pixel(directed_rows[row].new_image, directed_rows[row].color,
                    directed_rows[row].typed, directed_rows[row].want);
      end

      // random images: most open with a marker; big ones run past a full palette
      random_sent = 0;
      first_image = 1'b1;
      while (random_sent < RANDOM_ITEMS) begin
         big_image   = first_image || ($urandom_range(0, 7) == 0);
         first_image = 1'b0;
         image_len   = big_image ? $urandom_range(320, 380) : $urandom_range(3, 60);
         sender_calm = ($urandom_range(0, 4) == 0);
         pool_size   = $urandom_range(1, 24);
         color_pool.delete();
         image_colors.delete();
         for (p = 0; p < pool_size; p++) begin
            // some pool colors sit one bit away from another
            if (p > 0 && $urandom_range(0, 9) < 3)
               color_pool.push_back(color_pool[0] ^ (32'd1 << $urandom_range(0, 31)));
            else
               color_pool.push_back($urandom());
         end
         for (k = 0; k < image_len && random_sent < RANDOM_ITEMS; k++) begin
            mark = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 199) == 0);
            if (big_image) begin
               if (image_colors.size() == 0 || $urandom_range(0, 99) < 85)
                  pixel = $urandom();
               else
                  pixel = image_colors[$urandom_range(0, image_colors.size() - 1)];
               image_colors.push_back(pixel);
            end else if ($urandom_range(0, 19) == 0) begin
               pixel = $urandom();
            end else begin
               pixel = color_pool[$urandom_range(0, pool_size - 1)];
            end
            send_pixel(mark, pixel, 1'b0, '0);
            random_sent++;
         end
      end

      req_valid   = 1'b0;
      sender_calm = 1'b0;
      while (expected_indices.size() != 0) @(posedge clock);
      repeat (PALETTE_DEPTH + 40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
